FILE: src/iprp_pkg.sv
// Shared types and constants for the indexed pixel row packer.
package iprp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Width of the size registers as seen on the configuration port.
    localparam int SIZE_W = 13;
    // Column and row counters hold values up to the maximum minus one.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);

    localparam int PIX_W  = 8;
    localparam int ADDR_W = 4;

    // Bytes one pixel can produce: one data byte and up to three pad bytes.
    localparam int CNT_W  = 3;

    // Pixel depth codes; any other code packs at 1 bpp.
    localparam logic [1:0] DEPTH_8BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;
    localparam logic [1:0] DEPTH_1BPP = 2'd2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Bytes a single pixel releases to the output side.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [PIX_W-1:0] first_byte;
        logic             row_end;
        logic             image_end;
    } burst_t;

endpackage

FILE: src/indexed_pixel_row_packer.sv
// Top level of the indexed pixel row packer: configuration, pixel input stage and byte output.
//
// Usage: one palette index per pixel arrives on the s_* stream, row-major. Packed bytes
// leave on the m_* stream: tdata is the byte, tlast marks the last byte caused by one
// pixel, tuser[0] marks the final padded byte of a row and tuser[1] the final byte of
// the image. At 8 bpp each pixel gives one byte, at 4 bpp every second pixel, at 1 bpp
// every eighth; the last pixel of a row also releases a partial byte and the zero bytes
// that pad the row to a multiple of four.
// Configuration (pixel_depth at 0x0, image_width at 0x4, image_height at 0x8) goes
// through the APB port and should be written while the stream is idle.
// A pixel accepted into the input register is packed into the output register once that
// register is free, and its first byte is offered from then on.
// Throughput: one pixel per cycle while each pixel yields at most one byte and the receiver
// is ready; a pixel that yields more bytes holds the output register, the single byte lane, until all are taken.
// When the receiver stalls, the output register holds its byte and the input register
// holds one more pixel before s_tready drops.
// Reset clears the row and column counters, the partial byte and both stages, and sets
// 8 bpp with a 1 x 1 image.
module indexed_pixel_row_packer
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iprp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] pixel_index
    // Packed byte output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] packed_byte
    output logic                           m_tlast,   // run_last
    output logic [1:0]                     m_tuser    // [0] row_end, [1] image_end
);

    logic [1:0]                    depth_reg;
    logic [iprp_pkg::SIZE_W-1:0]   width_reg;
    logic [iprp_pkg::SIZE_W-1:0]   height_reg;

    logic                          in_valid_reg;
    logic [iprp_pkg::PIX_W-1:0]    in_pixel_reg;

    logic [iprp_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [iprp_pkg::PIX_W-1:0]    byte_reg,  byte_next;
    logic                          row_end_reg;
    logic                          image_end_reg;

    logic                          cfg_write;
    logic                          out_fire;
    logic                          burst_free;
    logic                          proc;
    iprp_pkg::burst_t              burst;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= iprp_pkg::DEPTH_8BPP;
            width_reg  <= iprp_pkg::SIZE_W'(1);
            height_reg <= iprp_pkg::SIZE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                iprp_pkg::REG_DEPTH:  depth_reg  <= pwdata[1:0];
                iprp_pkg::REG_WIDTH:  width_reg  <= pwdata[iprp_pkg::SIZE_W-1:0];
                iprp_pkg::REG_HEIGHT: height_reg <= pwdata[iprp_pkg::SIZE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            iprp_pkg::REG_DEPTH:  prdata = {30'd0, depth_reg};
            iprp_pkg::REG_WIDTH:  prdata = {{(32-iprp_pkg::SIZE_W){1'b0}}, width_reg};
            iprp_pkg::REG_HEIGHT: prdata = {{(32-iprp_pkg::SIZE_W){1'b0}}, height_reg};
            default:              prdata = '0;
        endcase
    end

    // Handshake between the stages
    assign m_tvalid   = count_reg != '0;
    assign out_fire   = m_tvalid && m_tready;
    assign burst_free = (count_reg == '0) || (count_reg == iprp_pkg::CNT_W'(1) && m_tready);
    assign proc       = in_valid_reg && burst_free;
    assign s_tready   = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_pixel_reg <= s_tdata;
    end

    iprp_packer u_packer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (proc),
        .pixel  (in_pixel_reg),
        .depth  (depth_reg),
        .width  (width_reg),
        .height (height_reg),
        .burst  (burst)
    );

    // Output register: the data byte first, then zero pad bytes.
    always_comb
    begin
        count_next = count_reg;
        byte_next  = byte_reg;
        if (out_fire)
        begin
            count_next = count_reg - iprp_pkg::CNT_W'(1);
            byte_next  = '0;
        end
        if (proc && burst.count != '0)
        begin
            count_next = burst.count;
            byte_next  = burst.first_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (proc && burst.count != '0)
        begin
            row_end_reg   <= burst.row_end;
            image_end_reg <= burst.image_end;
        end
    end

    assign m_tdata    = byte_reg;
    assign m_tlast    = count_reg == iprp_pkg::CNT_W'(1);
    assign m_tuser[0] = m_tlast && row_end_reg;
    assign m_tuser[1] = m_tlast && image_end_reg;

    // No pixel yields more than a data byte and three pad bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iprp_pkg::CNT_W'(4))
        else $error("output byte count out of range");

    // Every byte after the first of a pixel's run is padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && count_reg > iprp_pkg::CNT_W'(1) |=> m_tdata == '0)
        else $error("nonzero pad byte");

    // The end of the image is always the end of a row and of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("image end without row end");

    // A pixel held in the input stage is not dropped while the output is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("input stage lost a pixel");

endmodule

FILE: src/iprp_packer.sv
// Packing state and per-pixel packing logic of the indexed pixel row packer.
module iprp_packer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [iprp_pkg::PIX_W-1:0]       pixel,
    input  logic [1:0]                       depth,
    input  logic [iprp_pkg::SIZE_W-1:0]      width,
    input  logic [iprp_pkg::SIZE_W-1:0]      height,
    output iprp_pkg::burst_t                 burst
);

    logic [iprp_pkg::COL_W-1:0] col_reg,   col_next;
    logic [iprp_pkg::ROW_W-1:0] row_reg,   row_next;
    logic [iprp_pkg::PIX_W-1:0] acc_reg,   acc_next;
    logic [1:0]                 phase_reg, phase_next;

    logic [iprp_pkg::SIZE_W-1:0] width_eff;
    logic [iprp_pkg::SIZE_W-1:0] height_eff;
    logic [iprp_pkg::SIZE_W-1:0] col_plus;
    logic [iprp_pkg::SIZE_W-1:0] row_plus;
    logic                        last_col;
    logic                        last_row;
    logic                        has_data;
    logic [iprp_pkg::PIX_W-1:0]  data_byte;
    logic [iprp_pkg::PIX_W-1:0]  bit_mask;
    logic [iprp_pkg::PIX_W-1:0]  acc_base;
    logic [1:0]                  phase_after;
    logic [1:0]                  pad_count;

    always_comb
    begin
        if (width == '0)
            width_eff = iprp_pkg::SIZE_W'(1);
        else if (width > iprp_pkg::SIZE_W'(iprp_pkg::MAX_WIDTH))
            width_eff = iprp_pkg::SIZE_W'(iprp_pkg::MAX_WIDTH);
        else
            width_eff = width;

        if (height == '0)
            height_eff = iprp_pkg::SIZE_W'(1);
        else if (height > iprp_pkg::SIZE_W'(iprp_pkg::MAX_HEIGHT))
            height_eff = iprp_pkg::SIZE_W'(iprp_pkg::MAX_HEIGHT);
        else
            height_eff = height;
    end

    assign col_plus = iprp_pkg::SIZE_W'(col_reg) + iprp_pkg::SIZE_W'(1);
    assign row_plus = iprp_pkg::SIZE_W'(row_reg) + iprp_pkg::SIZE_W'(1);
    // A counter already past a newly shortened size also ends its row or image.
    assign last_col = col_plus >= width_eff;
    assign last_row = row_plus >= height_eff;

    assign bit_mask = (pixel != '0) ? (8'h80 >> col_reg[2:0]) : '0;
    assign acc_base = (col_reg[2:0] == 3'd0) ? '0 : acc_reg;

    always_comb
    begin
        has_data  = 1'b0;
        data_byte = '0;
        acc_next  = acc_reg;
        case (depth)
            iprp_pkg::DEPTH_8BPP:
            begin
                has_data  = 1'b1;
                data_byte = pixel;
            end
            iprp_pkg::DEPTH_4BPP:
            begin
                if (!col_reg[0])
                begin
                    // High nibble starts a fresh byte; it goes out alone at row end.
                    acc_next  = {pixel[3:0], 4'h0};
                    data_byte = {pixel[3:0], 4'h0};
                    has_data  = last_col;
                end
                else
                begin
                    // The whole partial byte is kept, since a depth change mid-row
                    // can leave bits in the low nibble.
                    data_byte = acc_reg | {4'h0, pixel[3:0]};
                    has_data  = 1'b1;
                    acc_next  = '0;
                end
            end
            default:
            begin
                data_byte = acc_base | bit_mask;
                acc_next  = acc_base | bit_mask;
                if (col_reg[2:0] == 3'd7 || last_col)
                begin
                    has_data = 1'b1;
                    acc_next = '0;
                end
            end
        endcase

        phase_after = phase_reg + 2'(has_data);
        pad_count   = last_col ? (2'd0 - phase_after) : 2'd0;

        if (last_col)
        begin
            acc_next   = '0;
            col_next   = '0;
            phase_next = 2'd0;
            row_next   = last_row ? '0 : iprp_pkg::ROW_W'(row_plus);
        end
        else
        begin
            col_next   = iprp_pkg::COL_W'(col_plus);
            phase_next = phase_after;
            row_next   = row_reg;
        end
    end

    always_comb
    begin
        burst.count      = iprp_pkg::CNT_W'(has_data) + iprp_pkg::CNT_W'(pad_count);
        burst.first_byte = has_data ? data_byte : '0;
        burst.row_end    = last_col;
        burst.image_end  = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            acc_reg   <= '0;
            phase_reg <= 2'd0;
        end
        else if (step)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
        end
    end

endmodule
